FILE: hw/rtl/bspe_pkg.sv
package bspe_pkg;

  // Sizes
  localparam int unsigned MaxEdges   = 256;
  localparam int unsigned EdgeAw     = 8;   // edge store address
  localparam int unsigned EdgeCw     = 9;   // edge count, holds MaxEdges
  localparam int unsigned VertSlots  = 64;
  localparam int unsigned VertW      = 6;
  localparam int unsigned QueueCw    = 7;   // queue pointers, hold VertSlots

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_PATH  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOCONN   = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Input beat
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] first_vertex;
    logic [7:0] second_vertex;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]       status;
    logic [VertW-1:0] path_vertex;
    logic             last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       clr_edges;
    logic       add_edge;
    logic       emit_single;
    logic [1:0] emit_status;
    logic       emit_src;
    logic       init_search;
    logic       deq;
    logic       latch_node;
    logic       scan;
    logic       walk_init;
    logic       walk;
    logic       walk_latch;
    logic       emit_rd;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       add_bad;
    logic       add_full;
    logic       path_bad;
    logic       path_same;
    logic       q_empty;
    logic       hit_dst;
    logic       scan_done;
    logic       walk_at_src;
    logic       emit_final;
  } dp_stat_t;

endpackage

FILE: hw/rtl/bspe_dp.sv
module bspe_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bspe_pkg::item_t              item_i,
  input  logic [bspe_pkg::VertW-1:0]   vcount_i,
  input  logic                         cfg_clr_i,
  input  bspe_pkg::dp_cmd_t            cmd_i,
  output bspe_pkg::dp_stat_t           stat_o,
  output logic                         res_strobe_o,
  output bspe_pkg::result_t            res_o
);

  localparam int unsigned VW = bspe_pkg::VertW;
  localparam int unsigned QW = bspe_pkg::QueueCw;
  localparam int unsigned EW = bspe_pkg::EdgeCw;

  // Storage
  logic [2*VW-1:0] edge_mem   [bspe_pkg::MaxEdges];
  logic [VW-1:0]   parent_mem [bspe_pkg::VertSlots];
  logic [VW-1:0]   queue_mem  [bspe_pkg::VertSlots];
  logic [VW-1:0]   stack_mem  [bspe_pkg::VertSlots];

  bspe_pkg::item_t   item_q;
  bspe_pkg::result_t res_q;
  logic [EW-1:0]     edge_total_q, idx_q;
  logic [bspe_pkg::VertSlots-1:0] visited_q;
  logic [QW-1:0]     head_q, tail_q, n_q;
  logic [VW-1:0]     node_q, walk_v_q;
  logic [VW-1:0]     queue_rd_q, parent_rd_q, stack_rd_q;
  logic [2*VW-1:0]   edge_rd_q;
  logic              pend_q, out_pend_q, out_last_q, res_strobe_q;

  logic [VW-1:0] src, dst, ea, eb, nb;
  logic [7:0]    vc8;
  logic          ma, mb, hit, q_room, idx_live;

  assign src = item_q.first_vertex[VW-1:0];
  assign dst = item_q.second_vertex[VW-1:0];
  assign vc8 = {2'b00, vcount_i};

  // Edge under test against the current node
  assign ea       = edge_rd_q[2*VW-1:VW];
  assign eb       = edge_rd_q[VW-1:0];
  assign ma       = (ea == node_q);
  assign mb       = (eb == node_q);
  assign nb       = ma ? eb : ea;
  assign hit      = cmd_i.scan && pend_q && (ma || mb) && !visited_q[nb];
  assign q_room   = (tail_q < QW'(bspe_pkg::VertSlots));
  assign idx_live = (idx_q < edge_total_q);

  // Status toward the controller
  always_comb begin
    stat_o.op          = item_q.operation;
    stat_o.add_bad     = (item_q.first_vertex == 8'd0) || (item_q.second_vertex == 8'd0) ||
                         (item_q.first_vertex > vc8) || (item_q.second_vertex > vc8);
    stat_o.add_full    = (edge_total_q == EW'(bspe_pkg::MaxEdges));
    stat_o.path_bad    = (item_q.first_vertex > vc8) || (item_q.second_vertex > vc8);
    stat_o.path_same   = (item_q.first_vertex == item_q.second_vertex);
    stat_o.q_empty     = (head_q == tail_q);
    stat_o.hit_dst     = hit && (nb == dst);
    stat_o.scan_done   = !pend_q && !idx_live;
    stat_o.walk_at_src = (walk_v_q == src);
    stat_o.emit_final  = (n_q == QW'(1));
  end

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      n_q          <= '0;
      out_pend_q   <= 1'b0;
      out_last_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      // edge count
      if (cfg_clr_i || cmd_i.clr_edges) begin
        edge_total_q <= '0;
      end else if (cmd_i.add_edge) begin
        edge_total_q <= edge_total_q + EW'(1);
      end
      // search queue and marks, only the source marked at start
      if (cmd_i.init_search) begin
        visited_q <= bspe_pkg::VertSlots'(1) << src;
        head_q <= '0;
        tail_q <= QW'(1);
      end else begin
        if (cmd_i.deq) begin
          head_q <= head_q + QW'(1);
        end
        if (hit) begin
          visited_q[nb] <= 1'b1;
          if (q_room) begin
            tail_q <= tail_q + QW'(1);
          end
        end
      end
      // edge scan
      if (cmd_i.latch_node) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= idx_live;
        if (idx_live) begin
          idx_q <= idx_q + EW'(1);
        end
      end
      // path stack depth
      if (cmd_i.walk_init) begin
        n_q <= '0;
      end else if (cmd_i.walk) begin
        n_q <= n_q + QW'(1);
      end else if (cmd_i.emit_rd) begin
        n_q <= n_q - QW'(1);
      end
      out_pend_q   <= cmd_i.emit_rd;
      out_last_q   <= (n_q == QW'(1));
      res_strobe_q <= cmd_i.emit_single || out_pend_q;
    end
  end

  // Node and walk pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_node) begin
      node_q <= queue_rd_q;
    end
    if (cmd_i.walk_init) begin
      walk_v_q <= dst;
    end else if (cmd_i.walk_latch) begin
      walk_v_q <= parent_rd_q;
    end
  end

  // Edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge) begin
      edge_mem[edge_total_q[bspe_pkg::EdgeAw-1:0]] <= {src, dst};
    end
    edge_rd_q <= edge_mem[idx_q[bspe_pkg::EdgeAw-1:0]];
  end

  // Search queue
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) begin
      queue_mem[0] <= src;
    end else if (hit && q_room) begin
      queue_mem[tail_q[VW-1:0]] <= nb;
    end
    queue_rd_q <= queue_mem[head_q[VW-1:0]];
  end

  // Parent links
  always_ff @(posedge clk_i) begin
    if (hit) begin
      parent_mem[nb] <= node_q;
    end
    parent_rd_q <= parent_mem[walk_v_q];
  end

  // Path stack, filled destination first and read back in reverse
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk) begin
      stack_mem[n_q[VW-1:0]] <= walk_v_q;
    end
    stack_rd_q <= stack_mem[n_q[VW-1:0] - VW'(1)];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      res_q.status      <= cmd_i.emit_status;
      res_q.path_vertex <= cmd_i.emit_src ? src : '0;
      res_q.last        <= 1'b1;
    end else if (out_pend_q) begin
      res_q.status      <= bspe_pkg::ST_OK;
      res_q.path_vertex <= stack_rd_q;
      res_q.last        <= out_last_q;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

FILE: hw/rtl/bspe_ctrl.sv
module bspe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bspe_pkg::dp_stat_t  stat_i,
  output bspe_pkg::dp_cmd_t   cmd_o,
  output logic                busy_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DEQ    = 4'd2;
  localparam logic [3:0] S_NODE   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_WALKW  = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (stat_i.op)
          bspe_pkg::OP_CLEAR: begin
            cmd_o.clr_edges   = 1'b1;
            cmd_o.emit_single = 1'b1;
            cmd_o.emit_status = bspe_pkg::ST_OK;
          end
          bspe_pkg::OP_ADD: begin
            cmd_o.emit_single = 1'b1;
            if (stat_i.add_bad) begin
              cmd_o.emit_status = bspe_pkg::ST_INVALID;
            end else if (stat_i.add_full) begin
              cmd_o.emit_status = bspe_pkg::ST_FULL;
            end else begin
              cmd_o.emit_status = bspe_pkg::ST_OK;
              cmd_o.add_edge    = 1'b1;
            end
          end
          bspe_pkg::OP_PATH: begin
            if (stat_i.path_bad) begin
              cmd_o.emit_single = 1'b1;
              cmd_o.emit_status = bspe_pkg::ST_INVALID;
            end else if (stat_i.path_same) begin
              cmd_o.emit_single = 1'b1;
              cmd_o.emit_status = bspe_pkg::ST_OK;
              cmd_o.emit_src    = 1'b1;
            end else begin
              cmd_o.init_search = 1'b1;
              state_d           = S_DEQ;
            end
          end
          bspe_pkg::OP_NONE: begin
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DEQ: begin
        if (stat_i.q_empty) begin
          cmd_o.emit_single = 1'b1;
          cmd_o.emit_status = bspe_pkg::ST_NOCONN;
          state_d           = S_IDLE;
        end else begin
          cmd_o.deq = 1'b1;
          state_d   = S_NODE;
        end
      end
      S_NODE: begin
        cmd_o.latch_node = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit_dst) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WALK;
        end else if (stat_i.scan_done) begin
          state_d = S_DEQ;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        state_d    = stat_i.walk_at_src ? S_EMIT : S_WALKW;
      end
      S_WALKW: begin
        cmd_o.walk_latch = 1'b1;
        state_d          = S_WALK;
      end
      S_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        if (stat_i.emit_final) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/bfs_shortest_path_engine_unit.sv
// Breadth-first shortest-path engine over an undirected edge list.
// Command channel: drive item_i and raise start; the beat is taken on a
// clock edge where start is high and busy is low. busy stays high until the
// item's last result has been loaded into the result register.
// Result channel: each result beat sits on result_o for one cycle, marked by
// result_strobe_o; the receiver cannot stall it. A path query that finds a
// path gives one beat per vertex from source to destination, last set on the
// final beat. Other items and outcomes give one beat (unused opcode: none).
// Search: a path query dequeues reached vertices in order and scans the
// stored edges for each, one edge per cycle, until the destination is
// reached or the queue runs empty; it then walks the parent links back
// from the destination and reads the path out in reverse.
// Configuration: APB, register 0 at address 0 is vertex_count (6 bits);
// writing it also drops all stored edges.
// Reset: vertex_count 1, no edges, controller idle, no result pending.
module bfs_shortest_path_engine_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  bspe_pkg::item_t             item_i,
  output logic                        result_strobe_o,
  output bspe_pkg::result_t           result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [bspe_pkg::VertW-1:0] vcount_q;
  logic                       cfg_wr;
  bspe_pkg::dp_cmd_t          cmd;
  bspe_pkg::dp_stat_t         stat;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= bspe_pkg::VertW'(1);
    end else if (cfg_wr) begin
      vcount_q <= pwdata[bspe_pkg::VertW-1:0];
    end
  end

  assign prdata = (paddr == 1'b0) ? {(32 - bspe_pkg::VertW)'(0), vcount_q} : 32'd0;

  bspe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bspe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .vcount_i     (vcount_q),
    .cfg_clr_i    (cfg_wr),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_strobe_o (result_strobe_o),
    .res_o        (result_o)
  );

  // A result beat only follows a cycle of work
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result beat without preceding work");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Error results end the item and carry no vertex
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (result_o.status != bspe_pkg::ST_OK)) |->
      (result_o.last && (result_o.path_vertex == '0)))
    else $error("error beat not final or carries a vertex");

endmodule
